>>> hw/rtl/bqe_pkg.sv
package bqe_pkg;

   localparam int CordicSteps = 24;
   localparam int StepW       = 5;
   localparam int CfgIdxW     = 3;

   localparam logic [CfgIdxW-1:0] CfgRightX = 3'd0;
   localparam logic [CfgIdxW-1:0] CfgRightY = 3'd1;
   localparam logic [CfgIdxW-1:0] CfgRightZ = 3'd2;
   localparam logic [CfgIdxW-1:0] CfgUpX    = 3'd3;
   localparam logic [CfgIdxW-1:0] CfgUpY    = 3'd4;
   localparam logic [CfgIdxW-1:0] CfgUpZ    = 3'd5;

   localparam logic signed [33:0] CordicGain = 34'sd652032874;

   typedef struct packed {
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] pos_z;
      logic signed [31:0] width;
      logic signed [31:0] height;
      logic signed [31:0] pivot_u;
      logic signed [31:0] pivot_v;
      logic [15:0]        angle;
      logic signed [31:0] tex_u0;
      logic signed [31:0] tex_v0;
      logic signed [31:0] tex_u1;
      logic signed [31:0] tex_v1;
   } req_type;

   typedef struct packed {
      logic               result_kind;
      logic signed [31:0] vert_x;
      logic signed [31:0] vert_y;
      logic signed [31:0] vert_z;
      logic signed [31:0] vert_u;
      logic signed [31:0] vert_v;
      logic [31:0]        index_value;
      logic               last;
   } rsp_type;

   typedef enum logic [3:0] {
      OP_IDLE, OP_LOAD, OP_CORDIC, OP_SINCOS, OP_DUDV, OP_ROT_A, OP_ROT_B,
      OP_PROJ_A, OP_PROJ_B, OP_VERT, OP_INDEX
   } op_type;

   typedef struct packed {
      op_type     op;
      logic [4:0] step;
      logic [1:0] corner;
      logic [2:0] idx;
      logic       last;
   } cmd_type;

   typedef struct packed {
      logic rsp_busy;
   } sts_type;

   function automatic logic signed [33:0] atan_val(input logic [StepW-1:0] i);
      logic signed [33:0] r;
      unique case (i)
         5'd0: r = 34'sd536870912;  5'd1: r = 34'sd316933406;
         5'd2: r = 34'sd167458907;  5'd3: r = 34'sd85004756;
         5'd4: r = 34'sd42667331;   5'd5: r = 34'sd21354465;
         5'd6: r = 34'sd10679838;   5'd7: r = 34'sd5340245;
         5'd8: r = 34'sd2670163;    5'd9: r = 34'sd1335087;
         5'd10: r = 34'sd667544;    5'd11: r = 34'sd333772;
         5'd12: r = 34'sd166886;    5'd13: r = 34'sd83443;
         5'd14: r = 34'sd41722;     5'd15: r = 34'sd20861;
         5'd16: r = 34'sd10430;     5'd17: r = 34'sd5215;
         5'd18: r = 34'sd2608;      5'd19: r = 34'sd1304;
         5'd20: r = 34'sd652;       5'd21: r = 34'sd326;
         5'd22: r = 34'sd163;       5'd23: r = 34'sd81;
         default: r = 34'sd0;
      endcase
      return r;
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [49:0] v);
      logic signed [31:0] r;
      if (v > 50'sd2147483647) r = 32'sh7fffffff;
      else if (v < -50'sd2147483648) r = 32'sh80000000;
      else r = v[31:0];
      return r;
   endfunction

endpackage

>>> hw/rtl/bqe_ctrl.sv
module bqe_ctrl import bqe_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  sts_type sts,
   output cmd_type cmd
);

   typedef enum logic [3:0] {
      S_IDLE, S_CORDIC, S_SINCOS, S_DUDV, S_ROT_A, S_ROT_B, S_PROJ_A, S_PROJ_B,
      S_VERT, S_INDEX
   } state_type;

   state_type  state_ff, state_in;
   logic [4:0] step_ff, step_in;
   logic [1:0] corner_ff, corner_in;
   logic [2:0] idx_ff, idx_in;

   assign req_stall = (state_ff != S_IDLE);

   always_comb begin
      state_in  = state_ff;
      step_in   = step_ff;
      corner_in = corner_ff;
      idx_in    = idx_ff;
      cmd       = '{op: OP_IDLE, step: step_ff, corner: corner_ff, idx: idx_ff,
                    last: 1'b0};
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.op    = OP_LOAD;
               state_in  = S_CORDIC;
               step_in   = '0;
               corner_in = '0;
               idx_in    = '0;
            end
         end
         S_CORDIC: begin
            cmd.op  = OP_CORDIC;
            step_in = step_ff + 5'd1;
            if (step_ff == 5'(CordicSteps - 1)) state_in = S_SINCOS;
         end
         S_SINCOS: begin
            cmd.op   = OP_SINCOS;
            state_in = S_DUDV;
         end
         S_DUDV: begin
            cmd.op   = OP_DUDV;
            state_in = S_ROT_A;
         end
         S_ROT_A: begin
            cmd.op   = OP_ROT_A;
            state_in = S_ROT_B;
         end
         S_ROT_B: begin
            cmd.op   = OP_ROT_B;
            state_in = S_PROJ_A;
         end
         S_PROJ_A: begin
            cmd.op   = OP_PROJ_A;
            state_in = S_PROJ_B;
         end
         S_PROJ_B: begin
            cmd.op   = OP_PROJ_B;
            state_in = S_VERT;
         end
         S_VERT: begin
            if (!sts.rsp_busy) begin
               cmd.op    = OP_VERT;
               corner_in = corner_ff + 2'd1;
               state_in  = (corner_ff == 2'd3) ? S_INDEX : S_DUDV;
            end
         end
         S_INDEX: begin
            if (!sts.rsp_busy) begin
               cmd.op   = OP_INDEX;
               cmd.last = (idx_ff == 3'd5);
               idx_in   = idx_ff + 3'd1;
               if (idx_ff == 3'd5) state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         step_ff   <= '0;
         corner_ff <= '0;
         idx_ff    <= '0;
      end else begin
         state_ff  <= state_in;
         step_ff   <= step_in;
         corner_ff <= corner_in;
         idx_ff    <= idx_in;
      end
   end

   a_step_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_CORDIC |-> step_ff < 5'(CordicSteps))
      else $error("cordic step out of range");
   a_idle_after_last: assert property (@(posedge clock) disable iff (reset)
      cmd.op == OP_INDEX && cmd.last |=> state_ff == S_IDLE)
      else $error("no return to idle after last index");
   a_load_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.op == OP_LOAD |-> state_ff == S_IDLE)
      else $error("load outside idle");

endmodule

>>> hw/rtl/bqe_datapath.sv
module bqe_datapath import bqe_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  req_type     req_data,
   input  logic        csr_write,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_data,
   input  cmd_type     cmd,
   output sts_type     sts,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_data
);

   logic signed [31:0] rx_ff, ry_ff, rz_ff, ux_ff, uy_ff, uz_ff;
   logic [31:0]        count_ff;
   req_type            item_ff;
   logic signed [33:0] cx_ff, cy_ff, cz_ff;
   logic signed [31:0] cos_ff, sin_ff;
   logic signed [31:0] du_ff, dv_ff, rdu_ff, rdv_ff;
   logic signed [63:0] pa_ff, pb_ff;
   logic signed [31:0] vx_ff, vy_ff, vz_ff;
   logic signed [63:0] tx_ff, ty_ff, tz_ff;
   logic               rsp_valid_ff;
   rsp_type            rsp_ff;

   logic signed [33:0] xs, ys;
   logic signed [31:0] cq, sq;
   logic signed [32:0] cu, cv, du_m, dv_m;
   logic signed [63:0] du_p, dv_p;
   logic signed [32:0] pvt;
   logic signed [64:0] rot_sum;
   logic signed [31:0] rsel;
   logic signed [31:0] vsel;

   function automatic logic signed [31:0] q16(input logic signed [33:0] v);
      logic signed [34:0] t;
      logic signed [20:0] r;
      t = 35'(v) + 35'sd8192;
      r = 21'(t >>> 14);
      if (r > 21'sd65536) r = 21'sd65536;
      if (r < -21'sd65536) r = -21'sd65536;
      return 32'(r);
   endfunction

   assign xs = cx_ff >>> cmd.step;
   assign ys = cy_ff >>> cmd.step;

   always_comb begin
      logic signed [31:0] cc, ss;
      cc = q16(cx_ff);
      ss = q16(cy_ff);
      unique case (item_ff.angle[15:14])
         2'd0: begin cq = cc;  sq = ss;  end
         2'd1: begin cq = -ss; sq = cc;  end
         2'd2: begin cq = -cc; sq = -ss; end
         default: begin cq = ss; sq = -cc; end
      endcase
   end

   assign cu   = (cmd.corner == 2'd1 || cmd.corner == 2'd2) ? 33'sd65536 : 33'sd0;
   assign cv   = (cmd.corner[1]) ? 33'sd65536 : 33'sd0;
   assign du_m = cu - 33'(item_ff.pivot_u);
   assign dv_m = cv - 33'(item_ff.pivot_v);
   assign du_p = 64'(du_m) * 64'(item_ff.width);
   assign dv_p = 64'(dv_m) * 64'(item_ff.height);
   assign pvt  = 33'sd0;
   assign rot_sum = 65'(pa_ff) + 65'(pb_ff);

   always_comb begin
      unique case (cmd.corner)
         2'd0: begin rsel = item_ff.tex_u0; vsel = item_ff.tex_v1; end
         2'd1: begin rsel = item_ff.tex_u1; vsel = item_ff.tex_v1; end
         2'd2: begin rsel = item_ff.tex_u1; vsel = item_ff.tex_v0; end
         default: begin rsel = item_ff.tex_u0; vsel = item_ff.tex_v0; end
      endcase
   end

   assign sts.rsp_busy = rsp_valid_ff && rsp_stall;
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_data     = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rx_ff <= 32'sd65536; ry_ff <= '0; rz_ff <= '0;
         ux_ff <= '0; uy_ff <= 32'sd65536; uz_ff <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_write) begin
            unique case (csr_index)
               CfgRightX: rx_ff <= csr_data;
               CfgRightY: ry_ff <= csr_data;
               CfgRightZ: rz_ff <= csr_data;
               CfgUpX:    ux_ff <= csr_data;
               CfgUpY:    uy_ff <= csr_data;
               CfgUpZ:    uz_ff <= csr_data;
               default: ;
            endcase
         end
         if (rsp_valid_ff && !rsp_stall) rsp_valid_ff <= 1'b0;
         if (cmd.op == OP_VERT || cmd.op == OP_INDEX) rsp_valid_ff <= 1'b1;
         if (cmd.op == OP_INDEX && cmd.last) count_ff <= count_ff + 32'd4;
      end
   end

   always_ff @(posedge clock) begin
      unique case (cmd.op)
         OP_LOAD: begin
            item_ff <= req_data;
            cx_ff   <= CordicGain;
            cy_ff   <= '0;
            cz_ff   <= 34'({req_data.angle[13:0], 16'd0});
         end
         OP_CORDIC: begin
            if (!cz_ff[33]) begin
               cx_ff <= cx_ff - ys; cy_ff <= cy_ff + xs;
               cz_ff <= cz_ff - atan_val(cmd.step);
            end else begin
               cx_ff <= cx_ff + ys; cy_ff <= cy_ff - xs;
               cz_ff <= cz_ff + atan_val(cmd.step);
            end
         end
         OP_SINCOS: begin
            cos_ff <= cq;
            sin_ff <= sq;
         end
         OP_DUDV: begin
            du_ff <= sat32(50'(du_p >>> 16));
            dv_ff <= sat32(50'(dv_p >>> 16));
         end
         OP_ROT_A: begin
            pa_ff  <= 64'(du_ff) * 64'(cos_ff);
            pb_ff  <= -(64'(dv_ff) * 64'(sin_ff));
            rdv_ff <= 32'(pvt);
         end
         OP_ROT_B: begin
            rdu_ff <= sat32(50'(rot_sum >>> 16));
            pa_ff  <= 64'(du_ff) * 64'(sin_ff);
            pb_ff  <= 64'(dv_ff) * 64'(cos_ff);
         end
         OP_PROJ_A: begin
            rdv_ff <= sat32(50'(rot_sum >>> 16));
            tx_ff  <= 64'(rx_ff) * 64'(rdu_ff);
            ty_ff  <= 64'(ry_ff) * 64'(rdu_ff);
            tz_ff  <= 64'(rz_ff) * 64'(rdu_ff);
         end
         OP_PROJ_B: begin
            vx_ff <= item_ff.pos_x + 32'(tx_ff >>> 16)
                     + 32'((64'(ux_ff) * 64'(rdv_ff)) >>> 16);
            vy_ff <= item_ff.pos_y + 32'(ty_ff >>> 16)
                     + 32'((64'(uy_ff) * 64'(rdv_ff)) >>> 16);
            vz_ff <= item_ff.pos_z + 32'(tz_ff >>> 16)
                     + 32'((64'(uz_ff) * 64'(rdv_ff)) >>> 16);
         end
         OP_VERT: begin
            rsp_ff <= '{result_kind: 1'b0, vert_x: vx_ff, vert_y: vy_ff,
                        vert_z: vz_ff, vert_u: rsel, vert_v: vsel,
                        index_value: 32'd0, last: 1'b0};
         end
         OP_INDEX: begin
            rsp_ff <= '{result_kind: 1'b1, vert_x: '0, vert_y: '0, vert_z: '0,
                        vert_u: '0, vert_v: '0, last: cmd.last,
                        index_value: count_ff + ((cmd.idx == 3'd1 ||
                           cmd.idx == 3'd5) ? 32'd2 : (cmd.idx == 3'd2) ? 32'd1 :
                           (cmd.idx == 3'd4) ? 32'd3 : 32'd0)};
         end
         default: ;
      endcase
   end

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_stall |-> !(cmd.op == OP_VERT || cmd.op == OP_INDEX))
      else $error("pending response overwritten");
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      cmd.op == OP_INDEX && cmd.last |=> count_ff == $past(count_ff) + 32'd4)
      else $error("vertex counter did not advance");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_stall |=> $stable(rsp_ff))
      else $error("stalled response changed");

endmodule

>>> hw/rtl/billboard_quad_expander.sv
// Sequence: an accepted request runs 24 CORDIC steps and a sine/cosine step,
// then for each vertex the DUDV, ROT_A, ROT_B, PROJ_A, PROJ_B and VERT steps on
// shared product registers; the four vertices are followed by six index responses.
// No new request is taken until the last index; a stalled response holds VERT/INDEX.
// Reset: synchronous; restores the camera vectors, clears the vertex counter.
module billboard_quad_expander import bqe_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_data,
   input  logic        csr_write,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_data
);

   cmd_type cmd;
   sts_type sts;

   bqe_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   bqe_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

>>> dv/tb_billboard_quad_expander.sv
module tb_billboard_quad_expander;
   import bqe_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int StallLimit = 4000;
   localparam int DrainCycles = 80;
   localparam logic [CfgIdxW-1:0] CfgSpareA = 3'd6;
   localparam logic [CfgIdxW-1:0] CfgSpareB = 3'd7;
   localparam longint Unity = 65536;

   localparam longint ArcTable [CordicSteps] = '{
      536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
      10679838, 5340245, 2670163, 1335087, 667544, 333772,
      166886, 83443, 41722, 20861, 10430, 5215,
      2608, 1304, 652, 326, 163, 81
   };

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   req_type     req_data;
   logic        rsp_valid;
   logic        rsp_stall;
   rsp_type     rsp_data;
   logic        csr_write;
   logic [2:0]  csr_index;
   logic [31:0] csr_data;

   longint  camera [6];
   logic [31:0] vertex_base;
   rsp_type pending_vertices [$];
   int      error_count;
   int      hold_left;
   int      burst_left;
   bit      quiet;
   int      idle_cycles;

   billboard_quad_expander DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_write(csr_write), .csr_index(csr_index), .csr_data(csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic longint clamp_word(input longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   function automatic longint q30_to_q16(input longint v);
      longint r;
      r = (v + 8192) >>> 14;
      if (r > Unity) r = Unity;
      if (r < -Unity) r = -Unity;
      return r;
   endfunction

   task automatic turn_to_cos_sin(input logic [15:0] a, output longint c, output longint s);
      longint x, y, z, xs, ys, cc, ss;
      x = 652032874;
      y = 0;
      z = longint'(a[13:0]) << 16;
      for (int i = 0; i < CordicSteps; i++) begin
         xs = x >>> i;
         ys = y >>> i;
         if (z >= 0) begin
            x = x - ys; y = y + xs; z = z - ArcTable[i];
         end else begin
            x = x + ys; y = y - xs; z = z + ArcTable[i];
         end
      end
      cc = q30_to_q16(x);
      ss = q30_to_q16(y);
      case (a[15:14])
         2'd0: begin c = cc;  s = ss;  end
         2'd1: begin c = -ss; s = cc;  end
         2'd2: begin c = -cc; s = -ss; end
         default: begin c = ss; s = -cc; end
      endcase
   endtask

   task automatic expand_billboard(input req_type r);
      longint c, s, cu, cv, du, dv, rdu, rdv, x, y, z;
      longint pu, pv, w, h;
      rsp_type o;
      logic [31:0] offsets [6];
      offsets = '{0, 2, 1, 0, 3, 2};
      pu = r.pivot_u; pv = r.pivot_v; w = r.width; h = r.height;
      turn_to_cos_sin(r.angle, c, s);
      for (int k = 0; k < 4; k++) begin
         cu = (k == 1 || k == 2) ? Unity : 0;
         cv = (k >= 2) ? Unity : 0;
         du = clamp_word(((cu - pu) * w) >>> 16);
         dv = clamp_word(((cv - pv) * h) >>> 16);
         rdu = clamp_word((du * c - dv * s) >>> 16);
         rdv = clamp_word((du * s + dv * c) >>> 16);
         x = longint'(r.pos_x) + ((camera[0] * rdu) >>> 16) + ((camera[3] * rdv) >>> 16);
         y = longint'(r.pos_y) + ((camera[1] * rdu) >>> 16) + ((camera[4] * rdv) >>> 16);
         z = longint'(r.pos_z) + ((camera[2] * rdu) >>> 16) + ((camera[5] * rdv) >>> 16);
         o = '0;
         o.vert_x = x[31:0];
         o.vert_y = y[31:0];
         o.vert_z = z[31:0];
         o.vert_u = (k == 0 || k == 3) ? r.tex_u0 : r.tex_u1;
         o.vert_v = (k >= 2) ? r.tex_v0 : r.tex_v1;
         pending_vertices.insert(pending_vertices.size(), o);
      end
      for (int k = 0; k < 6; k++) begin
         o = '0;
         o.result_kind = 1'b1;
         o.index_value = vertex_base + offsets[k];
         o.last = (k == 5);
         pending_vertices.insert(pending_vertices.size(), o);
      end
      vertex_base = vertex_base + 32'd4;
   endtask

   task automatic report_mismatch(input string field, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("mismatch %s: got %h want %h", field, got, want);
      error_count++;
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_vertices.size() == 0) begin
            report_mismatch("unexpected response", rsp_data.index_value, 32'd0);
         end else begin
            want = pending_vertices.pop_front();
            if (rsp_data.result_kind !== want.result_kind)
               report_mismatch("result_kind", 32'(rsp_data.result_kind),
                               32'(want.result_kind));
            if (rsp_data.vert_x !== want.vert_x)
               report_mismatch("vert_x", rsp_data.vert_x, want.vert_x);
            if (rsp_data.vert_y !== want.vert_y)
               report_mismatch("vert_y", rsp_data.vert_y, want.vert_y);
            if (rsp_data.vert_z !== want.vert_z)
               report_mismatch("vert_z", rsp_data.vert_z, want.vert_z);
            if (rsp_data.vert_u !== want.vert_u)
               report_mismatch("vert_u", rsp_data.vert_u, want.vert_u);
            if (rsp_data.vert_v !== want.vert_v)
               report_mismatch("vert_v", rsp_data.vert_v, want.vert_v);
            if (rsp_data.index_value !== want.index_value)
               report_mismatch("index_value", rsp_data.index_value, want.index_value);
            if (rsp_data.last !== want.last)
               report_mismatch("last", 32'(rsp_data.last), 32'(want.last));
         end
      end
   end

   always @(posedge clock) begin
      if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (quiet) begin
         rsp_stall <= 1'b0;
      end else if (burst_left > 0) begin
         rsp_stall <= 1'b1;
         burst_left <= burst_left - 1;
      end else if ($urandom_range(0, 4) == 0) begin
         rsp_stall <= 1'b1;
         burst_left <= $urandom_range(0, 5);
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= StallLimit) begin
         $display("tb_billboard_quad_expander: FAIL");
         $finish;
      end
   end

   task automatic send_billboard(input req_type r);
      req_data <= r;
      req_valid <= 1'b1;
      do @(posedge clock); while (req_stall);
      expand_billboard(r);
   endtask

   task automatic pause_sender(input int n);
      req_valid <= 1'b0;
      repeat (n) @(posedge clock);
   endtask

   task automatic maybe_pause;
      if (!quiet && $urandom_range(0, 3) == 0) pause_sender($urandom_range(1, 6));
   endtask

   task automatic drain;
      req_valid <= 1'b0;
      while (pending_vertices.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
   endtask

   task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      @(posedge clock);
      csr_write <= 1'b0;
      if (idx <= CfgUpZ) camera[idx] = longint'(signed'(value));
      @(posedge clock);
   endtask

   function automatic logic [31:0] pick_word;
      case ($urandom_range(0, 5))
         0: return $urandom;
         1: return 32'h7fffffff - $urandom_range(0, 3);
         2: return 32'h80000000 + $urandom_range(0, 3);
         3: return $urandom_range(0, 131072);
         4: return -$urandom_range(0, 131072);
         default: return $urandom_range(0, 8388608) - 32'd4194304;
      endcase
   endfunction

   function automatic req_type random_billboard;
      req_type r;
      r.pos_x = pick_word(); r.pos_y = pick_word(); r.pos_z = pick_word();
      r.width = pick_word(); r.height = pick_word();
      r.pivot_u = ($urandom_range(0, 2) == 0) ? pick_word() : $urandom_range(0, 65536);
      r.pivot_v = ($urandom_range(0, 2) == 0) ? pick_word() : $urandom_range(0, 65536);
      r.angle = 16'($urandom);
      r.tex_u0 = pick_word(); r.tex_v0 = pick_word();
      r.tex_u1 = pick_word(); r.tex_v1 = pick_word();
      return r;
   endfunction

   task automatic randomize_camera;
      write_reg(CfgRightX, pick_word());
      write_reg(CfgRightY, pick_word());
      write_reg(CfgRightZ, pick_word());
      write_reg(CfgUpX, pick_word());
      write_reg(CfgUpY, pick_word());
      write_reg(CfgUpZ, pick_word());
   endtask

   task automatic test_directed_corners;
      req_type r;
      logic [15:0] angles [8];
      angles = '{16'h0000, 16'h4000, 16'h8000, 16'hc000, 16'hffff, 16'h3fff, 16'h2000,
                 16'h0001};
      foreach (angles[i]) begin
         r = '0;
         r.pos_x = 32'h00010000 * i; r.pos_y = -32'h00020000; r.pos_z = 32'h00008000;
         r.width = 32'h00020000; r.height = 32'h00010000;
         r.pivot_u = 32'h00008000; r.pivot_v = 32'h00008000;
         r.angle = angles[i];
         r.tex_u0 = 0; r.tex_v0 = 0; r.tex_u1 = 32'h00010000; r.tex_v1 = 32'h00010000;
         send_billboard(r);
      end
      r = '1;
      r.pos_x = 32'h7fffffff; r.pos_y = 32'h7fffffff; r.pos_z = 32'h7fffffff;
      r.width = 32'h7fffffff; r.height = 32'h7fffffff;
      r.pivot_u = 32'h80000000; r.pivot_v = 32'h80000000;
      send_billboard(r);
      r = '0;
      r.pos_x = 32'h80000000; r.pos_y = 32'h80000000; r.pos_z = 32'h80000000;
      r.width = 32'h80000000; r.height = 32'h80000000;
      r.pivot_u = 32'h7fffffff; r.pivot_v = 32'h7fffffff; r.angle = 16'h6000;
      r.tex_u0 = 32'h80000000; r.tex_v1 = 32'h7fffffff;
      send_billboard(r);
      send_billboard('0);
      send_billboard('1);
      drain();
   endtask

   task automatic test_camera_extremes;
      write_reg(CfgRightX, 32'h7fffffff);
      write_reg(CfgRightY, 32'h80000000);
      write_reg(CfgRightZ, 32'hffffffff);
      write_reg(CfgUpX, 32'h80000000);
      write_reg(CfgUpY, 32'h7fffffff);
      write_reg(CfgUpZ, 32'h00000000);
      write_reg(CfgSpareA, 32'h12345678);
      write_reg(CfgSpareB, 32'hdeadbeef);
      for (int i = 0; i < 10; i++) begin
         send_billboard(random_billboard());
         maybe_pause();
      end
      drain();
   endtask

   task automatic test_output_backpressure;
      hold_left = 400;
      for (int i = 0; i < 12; i++) send_billboard(random_billboard());
      drain();
   endtask

   task automatic test_random_cameras;
      for (int phase = 0; phase < 4; phase++) begin
         randomize_camera();
         for (int i = 0; i < 60; i++) begin
            send_billboard(random_billboard());
            maybe_pause();
         end
         drain();
      end
   endtask

   task automatic test_streaming;
      quiet = 1'b1;
      write_reg(CfgRightX, 32'h00010000);
      write_reg(CfgRightY, 32'h00000000);
      write_reg(CfgRightZ, 32'h00000000);
      write_reg(CfgUpX, 32'h00000000);
      write_reg(CfgUpY, 32'h00010000);
      write_reg(CfgUpZ, 32'h00000000);
      for (int i = 0; i < 56; i++) send_billboard(random_billboard());
      drain();
   endtask

   initial begin
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_data <= '0;
      rsp_stall <= 1'b0;
      csr_write <= 1'b0;
      csr_index <= '0;
      csr_data <= '0;
      error_count = 0;
      hold_left = 0;
      burst_left = 0;
      quiet = 1'b0;
      idle_cycles = 0;
      vertex_base = '0;
      camera = '{Unity, 0, 0, 0, Unity, 0};
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_corners();
      test_camera_extremes();
      test_output_backpressure();
      test_random_cameras();
      test_streaming();
      if (error_count == 0)
         $display("tb_billboard_quad_expander: PASS");
      else
         $display("tb_billboard_quad_expander: FAIL");
      $finish;
   end

endmodule

>>> files.f
hw/rtl/bqe_pkg.sv
hw/rtl/bqe_ctrl.sv
hw/rtl/bqe_datapath.sv
hw/rtl/billboard_quad_expander.sv
dv/tb_billboard_quad_expander.sv
